// File: rtl/ste_pkg.sv
// Shared widths, codes, types and the solve microprogram of the similarity transform estimator.
package ste_pkg;

  localparam int CoordW   = 24;   // input coordinate, Q13.10
  localparam int SumW     = 30;   // coordinate sums
  localparam int SqW      = 54;   // product sums
  localparam int PieceW   = 24;   // low piece of a product sum
  localparam int MatW     = 32;   // matrix entry, Q15.16
  localparam int ShiftW   = 24;   // translation, Q13.10
  localparam int StatW    = 2;
  localparam int OpW      = 33;   // multiplier operand
  localparam int AccW     = 2 * OpW;
  localparam int PqW      = 62;   // p and q
  localparam int TW       = 20;   // covariance limit t
  localparam int DivW     = 61;   // divider remainder and divisor
  localparam int DivBitsW = 31;   // dividend bits streamed into the divider
  localparam int IterW    = 5;
  localparam int StepW    = 6;
  localparam int InDataW  = 4 * CoordW;
  localparam int OutDataW = 184;  // 178 bits of fields, zero filled to whole bytes

  localparam int MaxPairsDef = 64;

  localparam logic [StatW-1:0] STAT_OK   = 2'd0;
  localparam logic [StatW-1:0] STAT_ZVAR = 2'd1;
  localparam logic [StatW-1:0] STAT_ZCOV = 2'd2;
  localparam logic [StatW-1:0] STAT_OVF  = 2'd3;

  localparam logic signed [OpW-1:0] K_ONE_Q16 = 33'sd65536;
  localparam logic signed [OpW-1:0] K_EPS_Q20 = 33'sd105;

  localparam logic [IterW-1:0] ITERS_Q16   = 5'd31;
  localparam logic [IterW-1:0] ITERS_SHIFT = 5'd24;

  // operand selects
  localparam logic [4:0] SEL_SX   = 5'd0;
  localparam logic [4:0] SEL_SY   = 5'd1;
  localparam logic [4:0] SEL_DX   = 5'd2;
  localparam logic [4:0] SEL_DY   = 5'd3;
  localparam logic [4:0] SEL_N    = 5'd4;
  localparam logic [4:0] SEL_SSX  = 5'd5;
  localparam logic [4:0] SEL_SSY  = 5'd6;
  localparam logic [4:0] SEL_SDX  = 5'd7;
  localparam logic [4:0] SEL_SDY  = 5'd8;
  localparam logic [4:0] SEL_ACC  = 5'd9;
  localparam logic [4:0] SEL_T    = 5'd10;
  localparam logic [4:0] SEL_P    = 5'd11;
  localparam logic [4:0] SEL_Q    = 5'd12;
  localparam logic [4:0] SEL_M00  = 5'd13;
  localparam logic [4:0] SEL_M10  = 5'd14;
  localparam logic [4:0] SEL_K16  = 5'd15;
  localparam logic [4:0] SEL_K105 = 5'd16;
  localparam logic [4:0] SEL_SQH  = 5'd17;
  localparam logic [4:0] SEL_SQL  = 5'd18;
  localparam logic [4:0] SEL_XXH  = 5'd19;
  localparam logic [4:0] SEL_XXL  = 5'd20;
  localparam logic [4:0] SEL_XYH  = 5'd21;
  localparam logic [4:0] SEL_XYL  = 5'd22;
  localparam logic [4:0] SEL_YXH  = 5'd23;
  localparam logic [4:0] SEL_YXL  = 5'd24;
  localparam logic [4:0] SEL_YYH  = 5'd25;
  localparam logic [4:0] SEL_YYL  = 5'd26;

  localparam logic [1:0] BASE_ZERO = 2'd0;
  localparam logic [1:0] BASE_ACC  = 2'd1;
  localparam logic [1:0] BASE_DEST = 2'd2;

  localparam logic [3:0] DST_ACC = 4'd0;
  localparam logic [3:0] DST_SQ  = 4'd1;
  localparam logic [3:0] DST_XX  = 4'd2;
  localparam logic [3:0] DST_XY  = 4'd3;
  localparam logic [3:0] DST_YX  = 4'd4;
  localparam logic [3:0] DST_YY  = 4'd5;
  localparam logic [3:0] DST_S   = 4'd6;
  localparam logic [3:0] DST_P   = 4'd7;
  localparam logic [3:0] DST_Q   = 4'd8;
  localparam logic [3:0] DST_T   = 4'd9;

  // microprogram landmarks
  localparam logic [StepW-1:0] STEP_ACC_END = 6'd5;
  localparam logic [StepW-1:0] STEP_SOLVE   = 6'd6;
  localparam logic [StepW-1:0] STEP_S_END   = 6'd9;
  localparam logic [StepW-1:0] STEP_COV_END = 6'd26;
  localparam logic [StepW-1:0] STEP_TX      = 6'd27;
  localparam logic [StepW-1:0] STEP_TX_END  = 6'd29;
  localparam logic [StepW-1:0] STEP_TY      = 6'd30;
  localparam logic [StepW-1:0] STEP_TY_END  = 6'd32;

  typedef struct packed {
    logic       sh24;
    logic       neg;
  } mac_ctl_t;

  typedef struct packed {
    logic [4:0] sel_a;
    logic [4:0] sel_b;
    mac_ctl_t   ctl;
    logic [1:0] base;
    logic [3:0] dest;
  } uop_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_sts_t;

  // one multiply-accumulate per step: dest = base +/- (a * b << sh)
  function automatic uop_t ucode(input logic [StepW-1:0] step);
    uop_t u;
    u = '{SEL_N, SEL_N, '{1'b0, 1'b0}, BASE_ZERO, DST_ACC};
    case (step)
      // per pair accumulation
      6'd0:  u = '{SEL_SX,  SEL_SX,  '{1'b0, 1'b0}, BASE_DEST, DST_SQ};
      6'd1:  u = '{SEL_SY,  SEL_SY,  '{1'b0, 1'b0}, BASE_DEST, DST_SQ};
      6'd2:  u = '{SEL_DX,  SEL_SX,  '{1'b0, 1'b0}, BASE_DEST, DST_XX};
      6'd3:  u = '{SEL_DX,  SEL_SY,  '{1'b0, 1'b0}, BASE_DEST, DST_XY};
      6'd4:  u = '{SEL_DY,  SEL_SX,  '{1'b0, 1'b0}, BASE_DEST, DST_YX};
      6'd5:  u = '{SEL_DY,  SEL_SY,  '{1'b0, 1'b0}, BASE_DEST, DST_YY};
      // S = n*sum(x^2+y^2) - sx^2 - sy^2
      6'd6:  u = '{SEL_N,   SEL_SQH, '{1'b1, 1'b0}, BASE_ZERO, DST_ACC};
      6'd7:  u = '{SEL_N,   SEL_SQL, '{1'b0, 1'b0}, BASE_ACC,  DST_ACC};
      6'd8:  u = '{SEL_SSX, SEL_SSX, '{1'b0, 1'b1}, BASE_ACC,  DST_ACC};
      6'd9:  u = '{SEL_SSY, SEL_SSY, '{1'b0, 1'b1}, BASE_ACC,  DST_S};
      // p
      6'd10: u = '{SEL_N,   SEL_XXH, '{1'b1, 1'b0}, BASE_ZERO, DST_ACC};
      6'd11: u = '{SEL_N,   SEL_XXL, '{1'b0, 1'b0}, BASE_ACC,  DST_ACC};
      6'd12: u = '{SEL_N,   SEL_YYH, '{1'b1, 1'b0}, BASE_ACC,  DST_ACC};
      6'd13: u = '{SEL_N,   SEL_YYL, '{1'b0, 1'b0}, BASE_ACC,  DST_ACC};
      6'd14: u = '{SEL_SDX, SEL_SSX, '{1'b0, 1'b1}, BASE_ACC,  DST_ACC};
      6'd15: u = '{SEL_SDY, SEL_SSY, '{1'b0, 1'b1}, BASE_ACC,  DST_P};
      // q
      6'd16: u = '{SEL_N,   SEL_YXH, '{1'b1, 1'b0}, BASE_ZERO, DST_ACC};
      6'd17: u = '{SEL_N,   SEL_YXL, '{1'b0, 1'b0}, BASE_ACC,  DST_ACC};
      6'd18: u = '{SEL_N,   SEL_XYH, '{1'b1, 1'b1}, BASE_ACC,  DST_ACC};
      6'd19: u = '{SEL_N,   SEL_XYL, '{1'b0, 1'b1}, BASE_ACC,  DST_ACC};
      6'd20: u = '{SEL_SDY, SEL_SSX, '{1'b0, 1'b1}, BASE_ACC,  DST_ACC};
      6'd21: u = '{SEL_SDX, SEL_SSY, '{1'b0, 1'b0}, BASE_ACC,  DST_Q};
      // p^2 + q^2 - t^2 with t = 105 n^2
      6'd22: u = '{SEL_N,   SEL_N,   '{1'b0, 1'b0}, BASE_ZERO, DST_ACC};
      6'd23: u = '{SEL_ACC, SEL_K105,'{1'b0, 1'b0}, BASE_ZERO, DST_T};
      6'd24: u = '{SEL_T,   SEL_T,   '{1'b0, 1'b1}, BASE_ZERO, DST_ACC};
      6'd25: u = '{SEL_P,   SEL_P,   '{1'b0, 1'b0}, BASE_ACC,  DST_ACC};
      6'd26: u = '{SEL_Q,   SEL_Q,   '{1'b0, 1'b0}, BASE_ACC,  DST_ACC};
      // translation numerators
      6'd27: u = '{SEL_SDX, SEL_K16, '{1'b0, 1'b0}, BASE_ZERO, DST_ACC};
      6'd28: u = '{SEL_M00, SEL_SSX, '{1'b0, 1'b1}, BASE_ACC,  DST_ACC};
      6'd29: u = '{SEL_M10, SEL_SSY, '{1'b0, 1'b0}, BASE_ACC,  DST_ACC};
      6'd30: u = '{SEL_SDY, SEL_K16, '{1'b0, 1'b0}, BASE_ZERO, DST_ACC};
      6'd31: u = '{SEL_M10, SEL_SSX, '{1'b0, 1'b1}, BASE_ACC,  DST_ACC};
      6'd32: u = '{SEL_M00, SEL_SSY, '{1'b0, 1'b1}, BASE_ACC,  DST_ACC};
      default: u = '{SEL_N, SEL_N, '{1'b0, 1'b0}, BASE_ZERO, DST_ACC};
    endcase
    return u;
  endfunction

endpackage

// File: rtl/ste_mac.sv
// Shared signed multiply-accumulate unit of the similarity transform estimator.
module ste_mac (
  input  logic signed [ste_pkg::OpW-1:0]  a,
  input  logic signed [ste_pkg::OpW-1:0]  b,
  input  ste_pkg::mac_ctl_t               ctl,
  input  logic signed [ste_pkg::AccW-1:0] base,
  output logic signed [ste_pkg::AccW-1:0] res
);

  logic signed [ste_pkg::AccW-1:0] prod;
  logic signed [ste_pkg::AccW-1:0] term;

  assign prod = a * b;
  assign term = ctl.sh24 ? (prod <<< 24) : prod;
  assign res  = ctl.neg ? (base - term) : (base + term);

endmodule

// File: rtl/ste_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle, with overflow flag.
module ste_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ste_pkg::DivW-1:0]         r0,
  input  logic [ste_pkg::DivBitsW-1:0]     dbits,
  input  logic [ste_pkg::IterW-1:0]        iters,
  input  logic [ste_pkg::DivW-1:0]         dvsr,
  output logic [ste_pkg::DivBitsW-1:0]     quo,
  output ste_pkg::div_sts_t                sts
);

  logic                          busy_r, done_r, sat_r;
  logic [ste_pkg::IterW-1:0]     cnt_r;
  logic [ste_pkg::DivW-1:0]      rem_r, dv_r;
  logic [ste_pkg::DivBitsW-1:0]  bits_r, q_r;
  logic [ste_pkg::DivW:0]        trial;
  logic                          fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem_r, bits_r[ste_pkg::DivBitsW-1]};
  assign fits  = trial >= {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dv_r <= dvsr;
        q_r  <= '0;
        if (r0 >= dvsr) begin
          // quotient does not fit: flag and finish at once
          sat_r  <= 1'b1;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          sat_r  <= 1'b0;
          rem_r  <= r0;
          bits_r <= dbits;
          cnt_r  <= iters;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r  <= fits ? trial[ste_pkg::DivW-1:0] - dv_r : trial[ste_pkg::DivW-1:0];
        q_r    <= {q_r[ste_pkg::DivBitsW-2:0], fits};
        bits_r <= {bits_r[ste_pkg::DivBitsW-2:0], 1'b0};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == ste_pkg::IterW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo      = q_r;
  assign sts.done = done_r;
  assign sts.sat  = sat_r;

endmodule

// File: rtl/similarity_transform_estimator_core.sv
// Top level of the least-squares 2D similarity transform estimator.
// Point pairs arrive one per request on the in_ stream; each accepted pair is
// folded into the running sums by six products on the shared
// multiply-accumulate unit, and the block is not ready meanwhile. The
// request flagged by in_tlast starts the closed-form solve after its own six
// products: 21 steps on the same multiply-accumulate unit for the source
// variance, p, q and the covariance check, then the shift-subtract divider twice
// for the matrix entries (a start state and a wait state each) and twice for
// the translation (three multiply-accumulate steps, a magnitude state, a start
// state and a divider wait each), after which the result loads into the output
// register. Errors (status 1 to 3) finish early with a zero matrix and
// translation. The output register frees the input side: a new set may start
// while a result still waits on out_tready. Every result clears the sums. Pairs
// beyond MAX_PAIRS are dropped and the set then reports status 3.
module similarity_transform_estimator_core #(
  parameter int MAX_PAIRS = ste_pkg::MaxPairsDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // src_x [23:0], src_y [47:24], dst_x [71:48], dst_y [95:72]
  input  logic [ste_pkg::InDataW-1:0]       in_tdata,
  input  logic                              in_tlast,      // last_pair
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // m00 [31:0], m01 [63:32], m10 [95:64], m11 [127:96], shift_x [151:128],
  // shift_y [175:152], status [177:176], zero fill [183:178]
  output logic [ste_pkg::OutDataW-1:0]      out_tdata
);

  localparam int CntW = $clog2(MAX_PAIRS + 2);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAC   = 4'd1;
  localparam logic [3:0] S_D0GO  = 4'd2;
  localparam logic [3:0] S_D0W   = 4'd3;
  localparam logic [3:0] S_D1GO  = 4'd4;
  localparam logic [3:0] S_D1W   = 4'd5;
  localparam logic [3:0] S_ABS   = 4'd6;
  localparam logic [3:0] S_DTGO  = 4'd7;
  localparam logic [3:0] S_DTW   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  // control
  logic [3:0]                    state_r;
  logic [ste_pkg::StepW-1:0]     step_r;
  logic [CntW-1:0]               cnt_r;
  logic                          last_r, tsel_r, neg_r;
  logic [ste_pkg::StatW-1:0]     stat_r;
  logic                          out_valid_r;
  logic [ste_pkg::OutDataW-1:0]  out_data_r;

  // current pair
  logic signed [ste_pkg::CoordW-1:0] sx_r, sy_r, dx_r, dy_r;

  // running sums
  logic signed [ste_pkg::SumW-1:0] ssx_r, ssy_r, sdx_r, sdy_r;
  logic        [ste_pkg::SqW-1:0]  ssq_r;
  logic signed [ste_pkg::SqW-1:0]  sxx_r, sxy_r, syx_r, syy_r;

  // solve registers
  logic signed [ste_pkg::AccW-1:0]   acc_r;
  logic        [ste_pkg::AccW-1:0]   mag_r;
  logic        [ste_pkg::DivW-1:0]   s_r;
  logic signed [ste_pkg::PqW-1:0]    p_r, q_r;
  logic        [ste_pkg::TW-1:0]     t_r;
  logic signed [ste_pkg::MatW-1:0]   m00_r, m10_r;
  logic signed [ste_pkg::ShiftW-1:0] tx_r, ty_r;

  ste_pkg::uop_t                     uop;
  logic signed [ste_pkg::OpW-1:0]    opv [2];
  logic [4:0]                        sel [2];
  logic signed [ste_pkg::AccW-1:0]   base, res;
  logic                              in_acc, out_load, cov_small;

  // divider hookup
  logic                              div_start;
  logic [ste_pkg::DivW-1:0]          div_r0, div_dvsr;
  logic [ste_pkg::DivBitsW-1:0]      div_bits, div_q;
  logic [ste_pkg::IterW-1:0]         div_iters;
  ste_pkg::div_sts_t                 div_sts;
  logic signed [ste_pkg::PqW-1:0]    dsrc;
  logic [ste_pkg::PqW-1:0]           dmag;
  logic [ste_pkg::AccW-1:0]          tnum;
  logic [ste_pkg::DivBitsW-1:0]      qmag;
  logic signed [ste_pkg::MatW-1:0]   mq16;
  logic [ste_pkg::ShiftW-1:0]        q24, tres;
  logic signed [ste_pkg::MatW-1:0]   m01_w;

  function automatic logic fits31(input logic signed [ste_pkg::PqW-1:0] v);
    logic [ste_pkg::PqW-32:0] hi;
    hi = v[ste_pkg::PqW-1:31];
    return (hi == '0) || ((hi == '1) && (v[30:0] != '0));
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // operand selection for both multiplier ports
  assign uop    = ste_pkg::ucode(step_r);
  assign sel[0] = uop.sel_a;
  assign sel[1] = uop.sel_b;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      case (sel[k])
        ste_pkg::SEL_SX:   opv[k] = ste_pkg::OpW'(sx_r);
        ste_pkg::SEL_SY:   opv[k] = ste_pkg::OpW'(sy_r);
        ste_pkg::SEL_DX:   opv[k] = ste_pkg::OpW'(dx_r);
        ste_pkg::SEL_DY:   opv[k] = ste_pkg::OpW'(dy_r);
        ste_pkg::SEL_N:    opv[k] = signed'(ste_pkg::OpW'(cnt_r));
        ste_pkg::SEL_SSX:  opv[k] = ste_pkg::OpW'(ssx_r);
        ste_pkg::SEL_SSY:  opv[k] = ste_pkg::OpW'(ssy_r);
        ste_pkg::SEL_SDX:  opv[k] = ste_pkg::OpW'(sdx_r);
        ste_pkg::SEL_SDY:  opv[k] = ste_pkg::OpW'(sdy_r);
        ste_pkg::SEL_ACC:  opv[k] = acc_r[ste_pkg::OpW-1:0];
        ste_pkg::SEL_T:    opv[k] = signed'(ste_pkg::OpW'(t_r));
        ste_pkg::SEL_P:    opv[k] = p_r[ste_pkg::OpW-1:0];
        ste_pkg::SEL_Q:    opv[k] = q_r[ste_pkg::OpW-1:0];
        ste_pkg::SEL_M00:  opv[k] = ste_pkg::OpW'(m00_r);
        ste_pkg::SEL_M10:  opv[k] = ste_pkg::OpW'(m10_r);
        ste_pkg::SEL_K16:  opv[k] = ste_pkg::K_ONE_Q16;
        ste_pkg::SEL_K105: opv[k] = ste_pkg::K_EPS_Q20;
        ste_pkg::SEL_SQH:  opv[k] = signed'(ste_pkg::OpW'(ssq_r[ste_pkg::SqW-1:ste_pkg::PieceW]));
        ste_pkg::SEL_SQL:  opv[k] = signed'(ste_pkg::OpW'(ssq_r[ste_pkg::PieceW-1:0]));
        ste_pkg::SEL_XXH:  opv[k] = ste_pkg::OpW'(signed'(sxx_r[ste_pkg::SqW-1:ste_pkg::PieceW]));
        ste_pkg::SEL_XXL:  opv[k] = signed'(ste_pkg::OpW'(sxx_r[ste_pkg::PieceW-1:0]));
        ste_pkg::SEL_XYH:  opv[k] = ste_pkg::OpW'(signed'(sxy_r[ste_pkg::SqW-1:ste_pkg::PieceW]));
        ste_pkg::SEL_XYL:  opv[k] = signed'(ste_pkg::OpW'(sxy_r[ste_pkg::PieceW-1:0]));
        ste_pkg::SEL_YXH:  opv[k] = ste_pkg::OpW'(signed'(syx_r[ste_pkg::SqW-1:ste_pkg::PieceW]));
        ste_pkg::SEL_YXL:  opv[k] = signed'(ste_pkg::OpW'(syx_r[ste_pkg::PieceW-1:0]));
        ste_pkg::SEL_YYH:  opv[k] = ste_pkg::OpW'(signed'(syy_r[ste_pkg::SqW-1:ste_pkg::PieceW]));
        ste_pkg::SEL_YYL:  opv[k] = signed'(ste_pkg::OpW'(syy_r[ste_pkg::PieceW-1:0]));
        default:           opv[k] = '0;
      endcase
    end
  end

  always_comb begin
    case (uop.base)
      ste_pkg::BASE_ZERO: base = '0;
      ste_pkg::BASE_ACC:  base = acc_r;
      ste_pkg::BASE_DEST: begin
        case (uop.dest)
          ste_pkg::DST_SQ: base = signed'(ste_pkg::AccW'(ssq_r));
          ste_pkg::DST_XX: base = ste_pkg::AccW'(sxx_r);
          ste_pkg::DST_XY: base = ste_pkg::AccW'(sxy_r);
          ste_pkg::DST_YX: base = ste_pkg::AccW'(syx_r);
          ste_pkg::DST_YY: base = ste_pkg::AccW'(syy_r);
          default:         base = acc_r;
        endcase
      end
      default: base = '0;
    endcase
  end

  ste_mac u_mac (
    .a    (opv[0]),
    .b    (opv[1]),
    .ctl  (uop.ctl),
    .base (base),
    .res  (res)
  );

  // covariance below the limit only when both p and q fit in 31 bits
  assign cov_small = fits31(p_r) && fits31(q_r) && res[ste_pkg::AccW-1];

  // divider operands: Q16 quotient of |p| or |q| by S, or rounded translation by n
  assign dsrc = (state_r == S_D1GO) ? q_r : p_r;
  assign dmag = dsrc[ste_pkg::PqW-1] ? ste_pkg::PqW'(-dsrc) : ste_pkg::PqW'(dsrc);
  assign tnum = mag_r + (ste_pkg::AccW'(cnt_r) << 15);

  always_comb begin
    div_start = (state_r == S_D0GO) || (state_r == S_D1GO) || (state_r == S_DTGO);
    if (state_r == S_DTGO) begin
      div_r0    = ste_pkg::DivW'(tnum >> 40);
      div_bits  = {tnum[39:16], 7'b0};
      div_iters = ste_pkg::ITERS_SHIFT;
      div_dvsr  = ste_pkg::DivW'(cnt_r);
    end else begin
      div_r0    = ste_pkg::DivW'(dmag >> 15);
      div_bits  = {dmag[14:0], 16'b0};
      div_iters = ste_pkg::ITERS_Q16;
      div_dvsr  = s_r;
    end
  end

  ste_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .r0    (div_r0),
    .dbits (div_bits),
    .iters (div_iters),
    .dvsr  (div_dvsr),
    .quo   (div_q),
    .sts   (div_sts)
  );

  // saturate the Q16 magnitude and apply the sign
  assign qmag = div_sts.sat ? '1 : div_q;
  assign mq16 = (state_r == S_D1W ? q_r[ste_pkg::PqW-1] : p_r[ste_pkg::PqW-1])
                ? -signed'({1'b0, qmag}) : signed'({1'b0, qmag});

  // clamp the rounded translation to the signed 24-bit range
  always_comb begin
    q24 = div_q[ste_pkg::ShiftW-1:0];
    if (neg_r) begin
      if (div_sts.sat || (q24[ste_pkg::ShiftW-1] && (q24[ste_pkg::ShiftW-2:0] != '0)))
        q24 = {1'b1, {(ste_pkg::ShiftW-1){1'b0}}};
      tres = -q24;
    end else begin
      if (div_sts.sat || q24[ste_pkg::ShiftW-1])
        q24 = {1'b0, {(ste_pkg::ShiftW-1){1'b1}}};
      tres = q24;
    end
  end

  assign m01_w = -m10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      stat_r      <= ste_pkg::STAT_OK;
      ssx_r <= '0; ssy_r <= '0; sdx_r <= '0; sdy_r <= '0;
      ssq_r <= '0; sxx_r <= '0; sxy_r <= '0; syx_r <= '0; syy_r <= '0;
    end else begin
      // drop the valid once taken, unless a new result loads this cycle
      if (out_valid_r && out_tready && !out_load)
        out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            sx_r   <= signed'(in_tdata[23:0]);
            sy_r   <= signed'(in_tdata[47:24]);
            dx_r   <= signed'(in_tdata[71:48]);
            dy_r   <= signed'(in_tdata[95:72]);
            last_r <= in_tlast;
            if (cnt_r < CntW'(MAX_PAIRS)) begin
              stat_r  <= ste_pkg::STAT_OK;
              ssx_r   <= ssx_r + ste_pkg::SumW'(signed'(in_tdata[23:0]));
              ssy_r   <= ssy_r + ste_pkg::SumW'(signed'(in_tdata[47:24]));
              sdx_r   <= sdx_r + ste_pkg::SumW'(signed'(in_tdata[71:48]));
              sdy_r   <= sdy_r + ste_pkg::SumW'(signed'(in_tdata[95:72]));
              cnt_r   <= cnt_r + 1'b1;
              step_r  <= '0;
              state_r <= S_MAC;
            end else begin
              // drop the pair, remember the overflow
              cnt_r <= CntW'(MAX_PAIRS + 1);
              if (in_tlast) begin
                stat_r  <= ste_pkg::STAT_OVF;
                state_r <= S_OUT;
              end else begin
                stat_r  <= ste_pkg::STAT_OK;
              end
            end
          end
        end

        S_MAC: begin
          acc_r <= res;
          case (uop.dest)
            ste_pkg::DST_SQ: ssq_r <= res[ste_pkg::SqW-1:0];
            ste_pkg::DST_XX: sxx_r <= res[ste_pkg::SqW-1:0];
            ste_pkg::DST_XY: sxy_r <= res[ste_pkg::SqW-1:0];
            ste_pkg::DST_YX: syx_r <= res[ste_pkg::SqW-1:0];
            ste_pkg::DST_YY: syy_r <= res[ste_pkg::SqW-1:0];
            ste_pkg::DST_S:  s_r   <= res[ste_pkg::DivW-1:0];
            ste_pkg::DST_P:  p_r   <= res[ste_pkg::PqW-1:0];
            ste_pkg::DST_Q:  q_r   <= res[ste_pkg::PqW-1:0];
            ste_pkg::DST_T:  t_r   <= res[ste_pkg::TW-1:0];
            default: ;
          endcase
          step_r <= step_r + 1'b1;
          case (step_r)
            ste_pkg::STEP_ACC_END: begin
              if (!last_r)
                state_r <= S_IDLE;
            end
            ste_pkg::STEP_S_END: begin
              if (res[ste_pkg::AccW-1] || (res == '0)) begin
                stat_r  <= ste_pkg::STAT_ZVAR;
                state_r <= S_OUT;
              end
            end
            ste_pkg::STEP_COV_END: begin
              if (cov_small) begin
                stat_r  <= ste_pkg::STAT_ZCOV;
                state_r <= S_OUT;
              end else begin
                state_r <= S_D0GO;
              end
            end
            ste_pkg::STEP_TX_END: begin
              tsel_r  <= 1'b0;
              state_r <= S_ABS;
            end
            ste_pkg::STEP_TY_END: begin
              tsel_r  <= 1'b1;
              state_r <= S_ABS;
            end
            default: ;
          endcase
        end

        S_D0GO: state_r <= S_D0W;
        S_D0W: begin
          if (div_sts.done) begin
            m00_r   <= mq16;
            state_r <= S_D1GO;
          end
        end
        S_D1GO: state_r <= S_D1W;
        S_D1W: begin
          if (div_sts.done) begin
            m10_r   <= mq16;
            step_r  <= ste_pkg::STEP_TX;
            state_r <= S_MAC;
          end
        end

        S_ABS: begin
          neg_r   <= acc_r[ste_pkg::AccW-1];
          mag_r   <= acc_r[ste_pkg::AccW-1] ? ste_pkg::AccW'(-acc_r) : ste_pkg::AccW'(acc_r);
          state_r <= S_DTGO;
        end
        S_DTGO: state_r <= S_DTW;
        S_DTW: begin
          if (div_sts.done) begin
            if (!tsel_r) begin
              tx_r    <= signed'(tres);
              step_r  <= ste_pkg::STEP_TY;
              state_r <= S_MAC;
            end else begin
              ty_r    <= signed'(tres);
              state_r <= S_OUT;
            end
          end
        end

        S_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            if (stat_r == ste_pkg::STAT_OK)
              out_data_r <= {6'b0, stat_r, ty_r, tx_r, m00_r, m10_r, m01_w, m00_r};
            else
              out_data_r <= {6'b0, stat_r, {(ste_pkg::OutDataW-8){1'b0}}};
            // clear the sums for the next set
            cnt_r <= '0;
            ssx_r <= '0; ssy_r <= '0; sdx_r <= '0; sdy_r <= '0;
            ssq_r <= '0; sxx_r <= '0; sxy_r <= '0; syx_r <= '0; syy_r <= '0;
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an error result carries a zero matrix and translation
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[177:176] != ste_pkg::STAT_OK))
      |-> (out_data_r[175:0] == '0))
    else $error("error result with nonzero payload");

  // m01 mirrors m10 and m11 mirrors m00
  a_mat_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r[63:32] == -out_data_r[95:64])
                     && (out_data_r[127:96] == out_data_r[31:0])))
    else $error("matrix entries inconsistent");

  // every result leaves the sums cleared
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> ((cnt_r == '0) && (ssq_r == '0) && (ssx_r == '0)))
    else $error("state not cleared after result");

  // the pair count never runs past the overflow mark
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MAX_PAIRS + 1))
    else $error("pair count out of range");

  // the divider only reports while the solve waits on it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> ((state_r == S_D0W) || (state_r == S_D1W) || (state_r == S_DTW)))
    else $error("divider result outside a wait state");

endmodule
